/* design/llsf_pkg.sv */
// ----------------------------------------------------------------------------
// llsf_pkg
// Shared constants, types and helpers of the line literal substring filter:
// line and pattern sizes, register indexes, and the queue entry format.
// ----------------------------------------------------------------------------
package llsf_pkg;

    // Line and pattern sizing
    localparam int LINE_CAPACITY = 512;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int OUT_LEN_W     = 9;
    localparam int PAT_MAX       = 32;
    localparam int PAT_CNT_W     = $clog2(PAT_MAX + 1);
    localparam int PAT_IDX_W     = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int PAT_WORDS     = 4;
    localparam int WORD_W        = 64;
    localparam int PAT_BITS      = PAT_WORDS * WORD_W;
    localparam int PLEN_W        = 6;

    // Queue between front and back
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] ZERO_BYTE    = 8'h00;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_WORD0  = 3'd0,
        REG_PATTERN_WORD1  = 3'd1,
        REG_PATTERN_WORD2  = 3'd2,
        REG_PATTERN_WORD3  = 3'd3,
        REG_PATTERN_LENGTH = 3'd4
    } cfg_reg_t;

    // Work for the back part
    typedef enum logic {
        OP_STORE = 1'b0,
        OP_END   = 1'b1
    } llsf_op_t;

    typedef struct packed {
        llsf_op_t              op;
        logic [7:0]            data;
        logic [OUT_LEN_W-1:0]  length;
    } llsf_entry_t;

    // Low OUT_LEN_W bits of a line length, zero extended when narrower
    function automatic logic [OUT_LEN_W-1:0] len_field(input logic [LEN_W-1:0] len);
        logic [OUT_LEN_W+LEN_W-1:0] wide;
        wide = {{OUT_LEN_W{1'b0}}, len};
        return wide[OUT_LEN_W-1:0];
    endfunction

endpackage

/* design/line_literal_substring_filter.sv */
// ----------------------------------------------------------------------------
// line_literal_substring_filter
// Splits a byte stream into lines and reports, per line, its length and
// whether a configured literal pattern occurs in it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one text byte per transfer, or an
//   end-of-stream marker (stream_end) that closes a non-empty open line.
//   Output channel (out_valid/out_ready): one result per line end, carrying
//   line_matched and line_length.
//   Config channel (cfg_valid/cfg_ready): cfg_index selects pattern words
//   0..3 (8 bytes each, byte k at bits 8k) or pattern length (index 4);
//   other indexes are ignored. cfg_ready is always high. Write only when idle.
//   Throughput: one input byte per cycle while in_ready is high. A line-end
//   transfer enters the queue; at the queue head it loads the output register
//   once that is free, which raises out_valid. The window compare of each
//   byte is combinational.
//   Stall: a result held in the output register blocks the next line end at
//   the queue head; one more item fills the two-entry queue and in_ready drops.
//   Reset: pattern registers, line state and queue clear; no result pending.
// ----------------------------------------------------------------------------
module line_literal_substring_filter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          data_byte,
    input  logic                                stream_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                line_matched,
    output logic [llsf_pkg::OUT_LEN_W-1:0]      line_length,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [llsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [llsf_pkg::WORD_W-1:0]         cfg_data
);
    import llsf_pkg::*;

    logic [WORD_W-1:0] pat_word_reg [PAT_WORDS];
    logic [PLEN_W-1:0] pat_len_reg;
    logic [PAT_BITS-1:0] pattern_vec;
    logic              q_full;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    llsf_entry_t       push_entry;
    llsf_entry_t       q_head;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < PAT_WORDS; w++)
            begin
                pat_word_reg[w] <= '0;
            end
            pat_len_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PATTERN_WORD0:  pat_word_reg[0] <= cfg_data;
                REG_PATTERN_WORD1:  pat_word_reg[1] <= cfg_data;
                REG_PATTERN_WORD2:  pat_word_reg[2] <= cfg_data;
                REG_PATTERN_WORD3:  pat_word_reg[3] <= cfg_data;
                REG_PATTERN_LENGTH: pat_len_reg     <= cfg_data[PLEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Pack pattern words, word 0 lowest
    always_comb
    begin
        for (int w = 0; w < PAT_WORDS; w++)
        begin
            pattern_vec[w*WORD_W +: WORD_W] = pat_word_reg[w];
        end
    end

    llsf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    llsf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_valid),
        .head       (q_head)
    );

    llsf_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .pattern_vec    (pattern_vec),
        .pattern_length (pat_len_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .line_matched   (line_matched),
        .line_length    (line_length)
    );

endmodule

/* design/llsf_front.sv */
// ----------------------------------------------------------------------------
// llsf_front
// Input side: accepts text bytes, tracks the length of the open line and
// classifies each item as a stored byte, a line end, or a dropped flush.
// ----------------------------------------------------------------------------
module llsf_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_byte,
    input  logic                 stream_end,
    input  logic                 q_full,
    output logic                 q_push,
    output llsf_pkg::llsf_entry_t q_entry
);
    import llsf_pkg::*;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             accept;
    logic             line_open;
    logic             line_full;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign line_open = (len_reg != '0);
    assign line_full = (len_reg >= LEN_W'(LINE_CAPACITY - 1));

    // Classify the arriving item
    always_comb
    begin
        q_push         = 1'b0;
        q_entry.op     = OP_STORE;
        q_entry.data   = data_byte;
        q_entry.length = len_field(len_reg);
        len_next       = len_reg;
        if (accept)
        begin
            if (stream_end)
            begin
                if (line_open)
                begin
                    q_push     = 1'b1;
                    q_entry.op = OP_END;
                    len_next   = '0;
                end
            end
            else if (data_byte == NEWLINE_BYTE || line_full)
            begin
                q_push     = 1'b1;
                q_entry.op = OP_END;
                len_next   = '0;
            end
            else
            begin
                q_push   = 1'b1;
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    // Hold the open line's length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

endmodule

/* design/llsf_queue.sv */
// ----------------------------------------------------------------------------
// llsf_queue
// Short FIFO of classified items between the front and the back part.
// Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module llsf_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  llsf_pkg::llsf_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output llsf_pkg::llsf_entry_t head
);
    import llsf_pkg::*;

    llsf_entry_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* design/llsf_back.sv */
// ----------------------------------------------------------------------------
// llsf_back
// Matching side: shifts stored bytes into a window of the newest PAT_MAX
// bytes, compares it with the pattern each byte, and presents line results
// in an output register.
// ----------------------------------------------------------------------------
module llsf_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  llsf_pkg::llsf_entry_t           q_head,
    output logic                            q_pop,
    input  logic [llsf_pkg::PAT_BITS-1:0]   pattern_vec,
    input  logic [llsf_pkg::PLEN_W-1:0]     pattern_length,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            line_matched,
    output logic [llsf_pkg::OUT_LEN_W-1:0]  line_length
);
    import llsf_pkg::*;

    logic [7:0]           win_reg  [PAT_MAX];
    logic [7:0]           win_next [PAT_MAX];
    logic [7:0]           pat_byte [PAT_MAX];
    logic [7:0]           rev_pat  [PAT_MAX];
    logic [PAT_CNT_W-1:0] fill_reg;
    logic [PAT_CNT_W-1:0] fill_next;
    logic                 match_reg;
    logic                 zero_seen_reg;
    logic                 out_valid_reg;
    logic                 out_matched_reg;
    logic [OUT_LEN_W-1:0] out_length_reg;
    logic [PAT_CNT_W-1:0] cap_len;
    logic [PAT_CNT_W-1:0] eff_len;
    logic [PAT_CNT_W-1:0] rev_idx;
    logic [PAT_MAX-1:0]   pos_ok;
    logic                 hit;
    logic                 store_go;
    logic                 end_go;
    logic                 shift_go;

    // Pattern bytes, effective length up to the first zero byte
    always_comb
    begin
        cap_len = (pattern_length > PLEN_W'(PAT_MAX)) ? PAT_CNT_W'(PAT_MAX)
                                                      : PAT_CNT_W'(pattern_length);
        eff_len = cap_len;
        for (int k = 0; k < PAT_MAX; k++)
        begin
            pat_byte[k] = pattern_vec[8*k +: 8];
        end
        for (int k = PAT_MAX - 1; k >= 0; k--)
        begin
            if (PAT_CNT_W'(k) < cap_len && pat_byte[k] == ZERO_BYTE)
            begin
                eff_len = PAT_CNT_W'(k);
            end
        end
    end

    // Shift the new byte into the window and compare it with the pattern
    always_comb
    begin
        rev_idx     = '0;
        win_next[0] = q_head.data;
        for (int j = 1; j < PAT_MAX; j++)
        begin
            win_next[j] = win_reg[j-1];
        end
        fill_next = (fill_reg == PAT_CNT_W'(PAT_MAX)) ? fill_reg : fill_reg + PAT_CNT_W'(1);
        for (int j = 0; j < PAT_MAX; j++)
        begin
            rev_idx    = eff_len - PAT_CNT_W'(1) - PAT_CNT_W'(j);
            rev_pat[j] = pat_byte[rev_idx[PAT_IDX_W-1:0]];
            pos_ok[j]  = (PAT_CNT_W'(j) >= eff_len) || (win_next[j] == rev_pat[j]);
        end
        hit = (eff_len != '0) && (fill_next >= eff_len) && (&pos_ok);
    end

    // Pop a stored byte at once, a line end when the output slot frees
    assign store_go = q_valid && (q_head.op == OP_STORE);
    assign end_go   = q_valid && (q_head.op == OP_END) && (!out_valid_reg || out_ready);
    assign q_pop    = store_go || end_go;
    assign shift_go = store_go && !zero_seen_reg && (q_head.data != ZERO_BYTE);

    // Line state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            match_reg     <= 1'b0;
            zero_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (end_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (end_go)
            begin
                fill_reg      <= '0;
                match_reg     <= 1'b0;
                zero_seen_reg <= 1'b0;
            end
            else if (store_go && !zero_seen_reg)
            begin
                if (q_head.data == ZERO_BYTE)
                begin
                    zero_seen_reg <= 1'b1;
                end
                else
                begin
                    fill_reg <= fill_next;
                    if (hit)
                    begin
                        match_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Window bytes and result payload
    always_ff @(posedge clk)
    begin
        if (shift_go)
        begin
            for (int j = 0; j < PAT_MAX; j++)
            begin
                win_reg[j] <= win_next[j];
            end
        end
        if (end_go)
        begin
            out_matched_reg <= match_reg || (eff_len == '0);
            out_length_reg  <= q_head.length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_matched = out_matched_reg;
    assign line_length  = out_length_reg;

endmodule

/* design/llsf_checker.sv */
// ----------------------------------------------------------------------------
// llsf_checker
// Port-level checks of the line filter: result hold under stall, and input
// back-pressure only as a consequence of an output stall.
// ----------------------------------------------------------------------------
module llsf_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_ready,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               line_matched,
    input  logic [llsf_pkg::OUT_LEN_W-1:0]     line_length,
    input  logic                               cfg_ready
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(line_matched)
                                    && $stable(line_length))
        else $error("stalled result changed or dropped");

    // Back-pressure only after an output stall
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input stalled without an output stall");

    // No back-pressure while the output slot is empty
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // Configuration writes always complete
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind line_literal_substring_filter llsf_checker u_llsf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .line_matched (line_matched),
    .line_length  (line_length),
    .cfg_ready    (cfg_ready)
);
